// ===== hdl/pd_pkg.sv =====
// ----------------------------------------------------------------------------
// pd_pkg
// Shared types and constants of the percent-escape decoder.
// ----------------------------------------------------------------------------
package pd_pkg;

  localparam logic [7:0] PercentChar = 8'h25;
  localparam int unsigned MaxResults = 3;
  localparam int unsigned FifoDepth  = 4;
  localparam int unsigned PtrW       = $clog2(FifoDepth);
  localparam int unsigned CntW       = $clog2(FifoDepth + 1);

  typedef enum logic [1:0] {
    ERR_NONE      = 2'd0,
    ERR_TRUNCATED = 2'd1,
    ERR_ZERO      = 2'd2,
    ERR_INVALID   = 2'd3
  } err_e;

  typedef struct packed {
    logic [7:0] in_char;
    logic       last_char;
  } in_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic [1:0] error_code;
    logic       end_of_string;
  } out_t;

  // results produced by one decoded word
  typedef struct packed {
    logic [1:0]                  cnt;
    out_t [MaxResults-1:0]       res;
  } dec_t;

endpackage

// ===== hdl/pd_decode.sv =====
// ----------------------------------------------------------------------------
// pd_decode
// Escape state machine: turns one input word into zero to three results.
// ----------------------------------------------------------------------------
module pd_decode (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         fire_i,
  input  pd_pkg::in_t  item_i,
  input  logic         tolerant_i,
  output pd_pkg::dec_t dec_o
);

  typedef enum logic [1:0] {
    PH_IDLE   = 2'd0,
    PH_PCT    = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  phase_e     phase_q, phase_d;
  logic [7:0] first_q, first_d;
  logic       decoded_q, decoded_d;
  logic       discard_q, discard_d;

  function automatic logic [4:0] hex_val(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, 4'(c - 8'h30)};
    end else if (c >= 8'h41 && c <= 8'h46) begin
      r = {1'b1, 4'(c - 8'h37)};
    end else if (c >= 8'h61 && c <= 8'h66) begin
      r = {1'b1, 4'(c - 8'h57)};
    end
    return r;
  endfunction

  logic [4:0] hi, lo;
  logic [7:0] val;
  logic       c_last;
  logic [7:0] c;

  assign c      = item_i.in_char;
  assign c_last = item_i.last_char;
  assign hi     = hex_val(first_q);
  assign lo     = hex_val(c);
  assign val    = {hi[3:0], lo[3:0]};

  always_comb begin
    logic err;
    logic fin;
    pd_pkg::err_e code;
    err       = 1'b0;
    fin       = 1'b0;
    code      = pd_pkg::ERR_NONE;
    phase_d   = phase_q;
    first_d   = first_q;
    decoded_d = decoded_q;
    discard_d = discard_q;
    dec_o     = '0;

    if (discard_q) begin
      fin = c_last;
    end else begin
      unique case (phase_q)
        PH_IDLE: begin
          if (c == pd_pkg::PercentChar) begin
            if (c_last) begin
              err  = 1'b1;
              code = pd_pkg::ERR_TRUNCATED;
            end else begin
              phase_d = PH_PCT;
            end
          end else begin
            dec_o.cnt    = 2'd1;
            dec_o.res[0] = '{out_byte: c, error_code: pd_pkg::ERR_NONE,
                             end_of_string: c_last};
            fin          = c_last;
          end
        end
        PH_PCT: begin
          first_d = c;
          if (c_last) begin
            err  = 1'b1;
            code = pd_pkg::ERR_TRUNCATED;
          end else begin
            phase_d = PH_SECOND;
          end
        end
        PH_SECOND: begin
          phase_d = PH_IDLE;
          if (hi[4] && lo[4]) begin
            if (val == 8'd0) begin
              err  = 1'b1;
              code = pd_pkg::ERR_ZERO;
            end else begin
              dec_o.cnt    = 2'd1;
              dec_o.res[0] = '{out_byte: val, error_code: pd_pkg::ERR_NONE,
                               end_of_string: c_last};
              decoded_d    = 1'b1;
              fin          = c_last;
            end
          end else if (tolerant_i && !decoded_q) begin
            dec_o.cnt    = 2'd3;
            dec_o.res[0] = '{out_byte: pd_pkg::PercentChar,
                             error_code: pd_pkg::ERR_NONE, end_of_string: 1'b0};
            dec_o.res[1] = '{out_byte: first_q, error_code: pd_pkg::ERR_NONE,
                             end_of_string: 1'b0};
            dec_o.res[2] = '{out_byte: c, error_code: pd_pkg::ERR_NONE,
                             end_of_string: c_last};
            fin          = c_last;
          end else begin
            err  = 1'b1;
            code = pd_pkg::ERR_INVALID;
          end
        end
        default: begin
          phase_d = PH_IDLE;
        end
      endcase
    end

    if (err) begin
      dec_o.cnt    = 2'd1;
      dec_o.res[0] = '{out_byte: 8'd0, error_code: code, end_of_string: 1'b1};
      phase_d      = PH_IDLE;
      if (c_last) begin
        fin = 1'b1;
      end else begin
        discard_d = 1'b1;
      end
    end

    if (fin) begin
      phase_d   = PH_IDLE;
      decoded_d = 1'b0;
      discard_d = 1'b0;
    end

    if (!fire_i) begin
      dec_o.cnt = 2'd0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= PH_IDLE;
      first_q   <= 8'd0;
      decoded_q <= 1'b0;
      discard_q <= 1'b0;
    end else if (fire_i) begin
      phase_q   <= phase_d;
      first_q   <= first_d;
      decoded_q <= decoded_d;
      discard_q <= discard_d;
    end
  end

endmodule

// ===== hdl/pd_fifo.sv =====
// ----------------------------------------------------------------------------
// pd_fifo
// Result queue: takes up to three results per cycle, hands out one.
// ----------------------------------------------------------------------------
module pd_fifo (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  pd_pkg::dec_t              push_i,
  input  logic                      pop_i,
  output pd_pkg::out_t              head_o,
  output logic                      valid_o,
  output logic                      room_o,
  output logic [pd_pkg::CntW-1:0]   count_o
);

  pd_pkg::out_t [pd_pkg::FifoDepth-1:0] mem_q;
  logic [pd_pkg::PtrW-1:0] head_q, tail_q;
  logic [pd_pkg::CntW-1:0] count_q, count_d;

  assign head_o  = mem_q[head_q];
  assign valid_o = (count_q != '0);
  assign room_o  = (count_q <= pd_pkg::CntW'(pd_pkg::FifoDepth - pd_pkg::MaxResults));
  assign count_o = count_q;

  always_comb begin
    count_d = count_q + pd_pkg::CntW'(push_i.cnt)
            - pd_pkg::CntW'(pop_i && valid_o);
  end

  always_ff @(posedge clk_i) begin
    for (int i = 0; i < pd_pkg::MaxResults; i++) begin
      if (2'(i) < push_i.cnt) begin
        mem_q[tail_q + pd_pkg::PtrW'(i)] <= push_i.res[i];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q  <= '0;
      tail_q  <= '0;
      count_q <= '0;
    end else begin
      tail_q  <= tail_q + pd_pkg::PtrW'(push_i.cnt);
      if (pop_i && valid_o) begin
        head_q <= head_q + 1'b1;
      end
      count_q <= count_d;
    end
  end

endmodule

// ===== hdl/percent_escape_decoder_core.sv =====
// ----------------------------------------------------------------------------
// percent_escape_decoder_core
// URL percent-escape decoder, one character word in, zero to three bytes out.
// ----------------------------------------------------------------------------
// One character word is taken per cycle while in_stall_o is low. A word
// waits in the input register, is decoded there, and its results enter a
// four-entry result queue, which registers them before they show at the
// output. Input stalls only while the queue holds two or more results, and
// a stalled output backs up into the input. tolerant_mode is written through
// the cfg port, which is always ready.
module percent_escape_decoder_core (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  pd_pkg::in_t   in_i,
  output logic          out_valid_o,
  input  logic          out_stall_i,
  output pd_pkg::out_t  out_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  logic          cfg_data_i
);

  logic         tolerant_q;
  logic         in_valid_q, in_valid_d;
  pd_pkg::in_t  in_q;
  logic         room;
  logic         adv;
  logic         in_acc;
  pd_pkg::dec_t dec;
  logic [pd_pkg::CntW-1:0] count;

  assign cfg_ready_o = 1'b1;
  assign adv         = in_valid_q && room;
  assign in_stall_o  = in_valid_q && !room;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    in_valid_d = in_valid_q;
    if (in_acc) begin
      in_valid_d = 1'b1;
    end else if (adv) begin
      in_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tolerant_q <= 1'b0;
      in_valid_q <= 1'b0;
    end else begin
      in_valid_q <= in_valid_d;
      if (cfg_valid_i && cfg_ready_o) begin
        tolerant_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      in_q <= in_i;
    end
  end

  pd_decode u_decode (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .fire_i     (adv),
    .item_i     (in_q),
    .tolerant_i (tolerant_q),
    .dec_o      (dec)
  );

  pd_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (dec),
    .pop_i   (!out_stall_i),
    .head_o  (out_o),
    .valid_o (out_valid_o),
    .room_o  (room),
    .count_o (count)
  );

`ifndef SYNTHESIS
  a_count_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    count <= pd_pkg::CntW'(pd_pkg::FifoDepth))
    else $error("result queue overflow");

  a_err_form: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_o.error_code != pd_pkg::ERR_NONE) |->
      (out_o.end_of_string && out_o.out_byte == 8'd0))
    else $error("error result not terminal or byte nonzero");

  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && out_stall_i) |=> (out_valid_o && $stable(out_o)))
    else $error("stalled result lost or changed");

  a_no_push_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (dec.cnt != 2'd0) |-> (in_valid_q && room))
    else $error("results pushed without a decoded word");
`endif

endmodule
